### sv/pia_pkg.sv
// ----------------------------------------------------------------------------
// Priority indicator arbiter package
// Item codes, register indexes, item and slot view types, pin mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package pia_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_REQUEST     = 2'd0,
      KIND_RELEASE     = 2'd1,
      KIND_RELEASE_ALL = 2'd2,
      KIND_STEP        = 2'd3
   } kind_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEEP_ON  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEEP_GAP = 2'd1;

   localparam logic [15:0] BEEP_TIME_RESET = 16'd100;

   // Buzzer mode codes
   localparam logic [7:0] BUZZER_OFF    = 8'd0;
   localparam logic [7:0] BUZZER_ALWAYS = 8'd255;

   // One request channel item, as held in the input register
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  level;
      logic [7:0]  buzzer_mode;
      logic [2:0]  left_color;
      logic [2:0]  right_color;
      logic [15:0] blink_period;
      logic [15:0] hold_time;
      logic [31:0] now_ms;
   } req_item_type;

   // Winning slot as seen by the pin driver
   typedef struct packed {
      logic        found;
      logic [1:0]  level;
      logic [7:0]  buzzer;
      logic [2:0]  left;
      logic [2:0]  right;
      logic [15:0] blink;
      logic [7:0]  phase;
      logic [31:0] phase_time;
   } slot_view_type;

   // Left side has its red and green pins swapped
   function automatic logic [2:0] left_pin_map(input logic [2:0] color);
      return {color[2], color[0], color[1]};
   endfunction

endpackage

`default_nettype wire

### sv/pia_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying requests, releases and step items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pia_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  level;
   logic [7:0]  buzzer_mode;
   logic [2:0]  left_color;
   logic [2:0]  right_color;
   logic [15:0] blink_period;
   logic [15:0] hold_time;
   logic [31:0] now_ms;

   modport source (
      output valid, kind, level, buzzer_mode, left_color, right_color,
             blink_period, hold_time, now_ms,
      input  ready
   );
   modport sink (
      input  valid, kind, level, buzzer_mode, left_color, right_color,
             blink_period, hold_time, now_ms,
      output ready
   );
endinterface

`default_nettype wire

### sv/pia_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the latched buzzer and RGB pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pia_rsp_if;
   logic       valid;
   logic       ready;
   logic       buzzer_drive;
   logic [2:0] left_pins;
   logic [2:0] right_pins;
   logic [1:0] winner_level;

   modport source (
      output valid, buzzer_drive, left_pins, right_pins, winner_level,
      input  ready
   );
   modport sink (
      input  valid, buzzer_drive, left_pins, right_pins, winner_level,
      output ready
   );
endinterface

`default_nettype wire

### sv/pia_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pia_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

### sv/pia_slots.sv
// ----------------------------------------------------------------------------
// Priority indicator slot store
// One request slot per level: request/release handling, hold expiry,
// highest-level selection and the winner's beep phase.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_slots
   import pia_pkg::*;
#(
   parameter int unsigned LEVELS = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire req_item_type  item,
   input  wire logic          advance,
   output slot_view_type      view
);

   localparam int unsigned LVL_W = $clog2(LEVELS);

   logic [LEVELS-1:0] active_ff;
   logic [LEVELS-1:0] active_in;
   logic [15:0]       hold_ff [LEVELS];
   logic [15:0]       hold_in [LEVELS];
   logic [7:0]        buzzer_ff [LEVELS];
   logic [2:0]        left_ff [LEVELS];
   logic [2:0]        right_ff [LEVELS];
   logic [15:0]       blink_ff [LEVELS];
   logic [31:0]       start_ff [LEVELS];
   logic [7:0]        phase_ff [LEVELS];
   logic [31:0]       phase_time_ff [LEVELS];

   logic [LEVELS-1:0] alive;
   logic [LEVELS-1:0] same;
   logic              lvl_ok;
   logic [LVL_W-1:0]  lvl_idx;
   logic [LVL_W-1:0]  win_idx;
   logic              win_found;
   logic              wr_req;
   logic              wr_new;
   logic              renew;
   logic              is_step;

   // Decode the addressed level
   assign lvl_ok  = (item.level != 2'd0) && (32'(item.level) < LEVELS);
   assign lvl_idx = LVL_W'(item.level);
   assign is_step = fire && (item.kind == KIND_STEP);

   // Per-slot expiry and repeated-request match
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         alive[i] = active_ff[i] &&
                    !((hold_ff[i] != 16'd0) &&
                      ((item.now_ms - start_ff[i]) >= {16'd0, hold_ff[i]}));
         same[i]  = (buzzer_ff[i] == item.buzzer_mode) &&
                    (left_ff[i] == item.left_color) &&
                    (right_ff[i] == item.right_color) &&
                    (blink_ff[i] == item.blink_period);
      end
   end

   assign wr_req = fire && (item.kind == KIND_REQUEST) && lvl_ok;
   assign wr_new = wr_req && !(active_ff[lvl_idx] && same[lvl_idx]);
   assign renew  = wr_req && active_ff[lvl_idx] && same[lvl_idx] &&
                   (item.hold_time != 16'd0);

   // Pick the highest live level
   always_comb begin
      win_idx   = '0;
      win_found = 1'b0;
      for (int i = 1; i < LEVELS; i++) begin
         if (alive[i]) begin
            win_idx   = LVL_W'(i);
            win_found = 1'b1;
         end
      end
   end

   // Present the winner
   always_comb begin
      view.found      = win_found;
      view.level      = 2'(win_idx);
      view.buzzer     = buzzer_ff[win_idx];
      view.left       = left_ff[win_idx];
      view.right      = right_ff[win_idx];
      view.blink      = blink_ff[win_idx];
      view.phase      = phase_ff[win_idx];
      view.phase_time = phase_time_ff[win_idx];
   end

   // Next active flags and holds
   always_comb begin
      active_in = active_ff;
      hold_in   = hold_ff;
      if (fire) begin
         case (item.kind)
            KIND_REQUEST: begin
               if (wr_new) begin
                  active_in[lvl_idx] = 1'b1;
               end
               if (wr_new || renew) begin
                  hold_in[lvl_idx] = item.hold_time;
               end
            end
            KIND_RELEASE: begin
               if (lvl_ok) begin
                  active_in[lvl_idx] = 1'b0;
               end
            end
            KIND_RELEASE_ALL: begin
               active_in = '0;
            end
            default: begin
               active_in = alive;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            hold_ff[i] <= 16'd0;
         end
      end else begin
         active_ff <= active_in;
         hold_ff   <= hold_in;
      end
   end

   // Slot payload: new request, hold renewal, beep phase advance
   always_ff @(posedge clock) begin
      if (wr_new) begin
         buzzer_ff[lvl_idx]     <= item.buzzer_mode;
         left_ff[lvl_idx]       <= item.left_color;
         right_ff[lvl_idx]      <= item.right_color;
         blink_ff[lvl_idx]      <= item.blink_period;
         phase_ff[lvl_idx]      <= 8'd0;
         phase_time_ff[lvl_idx] <= item.now_ms;
      end
      if (wr_new || renew) begin
         start_ff[lvl_idx] <= item.now_ms;
      end
      if (is_step && advance) begin
         phase_ff[win_idx]      <= phase_ff[win_idx] + 8'd1;
         phase_time_ff[win_idx] <= item.now_ms;
      end
   end

endmodule

`default_nettype wire

### sv/pia_drive.sv
// ----------------------------------------------------------------------------
// Priority indicator pin driver
// Shared blink phase, winner's beep sequence and the latched pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_drive
   import pia_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire req_item_type  item,
   input  wire slot_view_type view,
   input  wire logic [15:0]   beep_on,
   input  wire logic [15:0]   beep_gap,
   output logic               advance,
   output logic               buzzer_drive,
   output logic [2:0]         left_pins,
   output logic [2:0]         right_pins,
   output logic [1:0]         winner_level
);

   logic [31:0] blink_time_ff;
   logic [31:0] blink_time_in;
   logic        blink_on_ff;
   logic        blink_on_in;
   logic        buzzer_ff;
   logic        buzzer_in;
   logic [2:0]  left_ff;
   logic [2:0]  left_in;
   logic [2:0]  right_ff;
   logic [2:0]  right_in;
   logic [1:0]  winner_ff;
   logic [1:0]  winner_in;

   logic        is_step;
   logic        blink_due;
   logic        show;
   logic [7:0]  beep_end;
   logic        beeping;
   logic        sounding;
   logic [15:0] beep_lim;
   logic        phase_due;
   logic        buzz;

   assign is_step = fire && (item.kind == KIND_STEP);

   // Blink half-period check
   assign blink_due = (item.now_ms - blink_time_ff) >= {16'd0, view.blink};

   // Beep sequence: even phases sound, odd phases are gaps
   assign beep_end  = {view.buzzer[6:0], 1'b0};
   assign beeping   = view.phase < beep_end;
   assign sounding  = !view.phase[0];
   assign beep_lim  = sounding ? beep_on : beep_gap;
   assign phase_due = (item.now_ms - view.phase_time) >= {16'd0, beep_lim};

   always_comb begin
      if (view.buzzer == BUZZER_OFF) begin
         buzz = 1'b0;
      end else if (view.buzzer == BUZZER_ALWAYS) begin
         buzz = 1'b1;
      end else begin
         buzz = beeping && sounding;
      end
   end

   assign advance = is_step && view.found && (view.buzzer != BUZZER_OFF) &&
                    (view.buzzer != BUZZER_ALWAYS) && beeping && phase_due;

   // Next blink phase and pin levels
   always_comb begin
      blink_time_in = blink_time_ff;
      blink_on_in   = blink_on_ff;
      buzzer_in     = buzzer_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      winner_in     = winner_ff;
      show          = 1'b1;
      if (is_step) begin
         winner_in = view.level;
         if (!view.found) begin
            blink_on_in   = 1'b1;
            blink_time_in = item.now_ms;
            buzzer_in     = 1'b0;
            left_in       = 3'd0;
            right_in      = 3'd0;
         end else begin
            if (view.blink != 16'd0) begin
               if (blink_due) begin
                  blink_time_in = item.now_ms;
                  blink_on_in   = !blink_on_ff;
               end
               show = blink_on_in;
            end
            buzzer_in = buzz;
            left_in   = show ? left_pin_map(view.left) : 3'd0;
            right_in  = show ? view.right : 3'd0;
         end
      end else if (fire && (item.kind == KIND_RELEASE_ALL)) begin
         buzzer_in = 1'b0;
         left_in   = 3'd0;
         right_in  = 3'd0;
         winner_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_time_ff <= 32'd0;
         blink_on_ff   <= 1'b1;
         buzzer_ff     <= 1'b0;
         left_ff       <= 3'd0;
         right_ff      <= 3'd0;
         winner_ff     <= 2'd0;
      end else begin
         blink_time_ff <= blink_time_in;
         blink_on_ff   <= blink_on_in;
         buzzer_ff     <= buzzer_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         winner_ff     <= winner_in;
      end
   end

   assign buzzer_drive = buzzer_ff;
   assign left_pins    = left_ff;
   assign right_pins   = right_ff;
   assign winner_level = winner_ff;

endmodule

`default_nettype wire

### sv/priority_indicator_arbiter.sv
// ----------------------------------------------------------------------------
// Priority indicator arbiter
// Arbitrates indicator requests by level and drives buzzer and RGB pins.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per handshake: a request, a release of one
//   level, a release of all levels, or a step with the current ms time.
//   rsp_ch returns one item per request item: the latched buzzer level,
//   left/right pin levels and the level that won the last step.
//   csr_ch writes the beep on time and beep gap time and is always ready;
//   it must be written only while the block is idle; the block never checks.
// Timing:
//   An accepted item sits in the input register until the result register
//   is free, is then worked by the slot store and pin driver, and its
//   result is registered in the result register.
//   One item per cycle is sustained while rsp_ready stays high.
// Reset:
//   All slots inactive, holds cleared, pins off, winner 0, blink phase on,
//   beep times 100 ms.
// Stall:
//   With rsp_ready low the result holds; one more item is taken into the
//   input register, after which req_ready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_indicator_arbiter
   import pia_pkg::*;
#(
   parameter int unsigned LEVELS = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pia_req_if.sink    req_ch,
   pia_rsp_if.source  rsp_ch,
   pia_csr_if.sink    csr_ch
);

   logic          in_valid_ff;
   logic          in_valid_in;
   req_item_type  item_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [15:0]   beep_on_ff;
   logic [15:0]   beep_on_in;
   logic [15:0]   beep_gap_ff;
   logic [15:0]   beep_gap_in;

   logic          fire;
   logic          req_take;
   logic          advance;
   slot_view_type view;

   // Work the held item when the result register is free
   assign fire     = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || fire;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind         <= kind_type'(req_ch.kind);
         item_ff.level        <= req_ch.level;
         item_ff.buzzer_mode  <= req_ch.buzzer_mode;
         item_ff.left_color   <= req_ch.left_color;
         item_ff.right_color  <= req_ch.right_color;
         item_ff.blink_period <= req_ch.blink_period;
         item_ff.hold_time    <= req_ch.hold_time;
         item_ff.now_ms       <= req_ch.now_ms;
      end
   end

   // Configuration registers
   assign csr_ch.ready = 1'b1;

   always_comb begin
      beep_on_in  = beep_on_ff;
      beep_gap_in = beep_gap_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BEEP_ON:  beep_on_in  = csr_ch.data;
            CSR_BEEP_GAP: beep_gap_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beep_on_ff  <= BEEP_TIME_RESET;
         beep_gap_ff <= BEEP_TIME_RESET;
      end else begin
         beep_on_ff  <= beep_on_in;
         beep_gap_ff <= beep_gap_in;
      end
   end

   pia_slots #(
      .LEVELS (LEVELS)
   ) u_slots (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item_ff),
      .advance (advance),
      .view    (view)
   );

   pia_drive u_drive (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item_ff),
      .view         (view),
      .beep_on      (beep_on_ff),
      .beep_gap     (beep_gap_ff),
      .advance      (advance),
      .buzzer_drive (rsp_ch.buzzer_drive),
      .left_pins    (rsp_ch.left_pins),
      .right_pins   (rsp_ch.right_pins),
      .winner_level (rsp_ch.winner_level)
   );

   assign rsp_ch.valid = out_valid_ff;

endmodule

`default_nettype wire

### test/priority_indicator_arbiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority indicator arbiter testbench
// Drives requests, releases, release-all and step items through the
// arbiter, checks every result against a typed-in want or a cycle-free
// predictor of the slot store, blink phase and beep train, and sweeps
// the beep timing registers over several settings, the extremes among them.
// ----------------------------------------------------------------------------
module priority_indicator_arbiter_tb;
   import pia_pkg::*;

   localparam int unsigned LEVELS       = 4;
   localparam int unsigned IDLE_PCT     = 12;
   localparam int unsigned RANDOM_ITEMS = 1800;
   localparam int unsigned PHASES       = 6;
   localparam int unsigned QUIET_PHASE  = 2;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_REPORTS  = 40;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   // Beep on/gap settings swept by the random phases
   localparam logic [15:0] BEEP_ON_PLAN  [PHASES] = '{16'd0, 16'd65535, 16'd5,
                                                      16'd40, 16'd0, 16'd12};
   localparam logic [15:0] BEEP_GAP_PLAN [PHASES] = '{16'd0, 16'd65535, 16'd17,
                                                      16'd3, 16'd65535, 16'd12};

   typedef struct packed {
      logic       buzzer;
      logic [2:0] left;
      logic [2:0] right;
      logic [1:0] winner;
   } pins_type;

   localparam pins_type PINS_OFF = '0;

   typedef struct {
      kind_type    kind;
      logic [1:0]  level;
      logic [7:0]  mode;
      logic [2:0]  lc;
      logic [2:0]  rc;
      logic [15:0] blink;
      logic [15:0] hold;
      logic [31:0] now;
      bit          typed;
      pins_type    want;
   } script_row_type;

   // Directed rows; want is typed in only where it is plain to see
   script_row_type script [26] = '{
      // after reset: no winner, pins off
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd0,   1'b1,
        PINS_OFF},
      // level 0 is ignored
      '{KIND_REQUEST,     2'd0, 8'd255, 3'd7, 3'd7, 16'd0,     16'd0,     32'd5,   1'b1,
        PINS_OFF},
      '{KIND_RELEASE,     2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd6,   1'b1,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd10,  1'b1,
        PINS_OFF},
      // a request shows only at the next step
      '{KIND_REQUEST,     2'd1, 8'd255, 3'd1, 3'd2, 16'd0,     16'd0,     32'd20,  1'b1,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd30,  1'b1,
        '{1'b1, 3'b010, 3'd2, 2'd1}},
      // higher level with a timed hold
      '{KIND_REQUEST,     2'd3, 8'd0,   3'd7, 3'd7, 16'd0,     16'd50,    32'd40,  1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd50,  1'b1,
        '{1'b0, 3'd7, 3'd7, 2'd3}},
      // hold runs out exactly, level 1 wins again
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd90,  1'b1,
        '{1'b1, 3'b010, 3'd2, 2'd1}},
      // blinking winner with a two-beep train
      '{KIND_REQUEST,     2'd2, 8'd2,   3'd4, 3'd1, 16'd100,   16'd0,     32'd100, 1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd100, 1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd150, 1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd200, 1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd300, 1'b0,
        PINS_OFF},
      // repeated request: renew the hold, then keep it with a zero hold
      '{KIND_REQUEST,     2'd2, 8'd2,   3'd4, 3'd1, 16'd100,   16'd65535, 32'd310, 1'b0,
        PINS_OFF},
      '{KIND_REQUEST,     2'd2, 8'd2,   3'd4, 3'd1, 16'd100,   16'd0,     32'd320, 1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd400, 1'b0,
        PINS_OFF},
      // beep count 128 is silent; shortest hold
      '{KIND_REQUEST,     2'd2, 8'd128, 3'd3, 3'd6, 16'd65535, 16'd1,     32'd500, 1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd500, 1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'd501, 1'b0,
        PINS_OFF},
      // beep count above 128 and a time stamp wrap
      '{KIND_REQUEST,     2'd3, 8'd129, 3'd5, 3'd3, 16'd0,     16'd0,
        32'hFFFF_FFF0, 1'b0, PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'h10,  1'b0,
        PINS_OFF},
      // release one leaves the pins until the next step
      '{KIND_RELEASE,     2'd3, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'h20,  1'b0,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'h30,  1'b0,
        PINS_OFF},
      // release all drops the pins at once
      '{KIND_RELEASE_ALL, 2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'h40,  1'b1,
        PINS_OFF},
      '{KIND_STEP,        2'd0, 8'd0,   3'd0, 3'd0, 16'd0,     16'd0,     32'h50,  1'b1,
        PINS_OFF}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pia_req_if req_ch ();
   pia_rsp_if rsp_ch ();
   pia_csr_if csr_ch ();

   priority_indicator_arbiter #(.LEVELS(LEVELS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted slot store, blink phase, timing and latched pins
   logic [15:0]  beep_on_ms;
   logic [15:0]  beep_gap_ms;
   logic         lamp_active   [LEVELS];
   logic [7:0]   lamp_buzzer   [LEVELS];
   logic [2:0]   lamp_left     [LEVELS];
   logic [2:0]   lamp_right    [LEVELS];
   logic [15:0]  lamp_blink    [LEVELS];
   logic [15:0]  lamp_hold     [LEVELS];
   logic [31:0]  lamp_start    [LEVELS];
   logic [7:0]   lamp_phase    [LEVELS];
   logic [31:0]  lamp_phase_ms [LEVELS];
   logic [31:0]  blink_mark;
   logic         blink_lit;
   pins_type     latched;
   pins_type     pin_queue [$];

   // Stimulus bookkeeping
   logic [31:0]  clock_ms;
   req_item_type recent_req   [LEVELS];
   bit           recent_valid [LEVELS];
   bit           quiet = 1'b0;
   int unsigned  errors = 0;
   int unsigned  checked = 0;
   int unsigned  random_sent = 0;
   int unsigned  cycle_count = 0;

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t ns: %s", $time, msg);
   endtask

   // Advance the predicted block by one accepted item
   task automatic apply_item(input req_item_type it, output pins_type res);
      logic [31:0] now;
      logic [1:0]  lv;
      logic [1:0]  win;
      logic        addressed;
      logic        same;
      logic        show;
      logic        sounding;
      logic [7:0]  beep_end;
      logic [15:0] limit_ms;
      now = it.now_ms;
      lv = it.level;
      addressed = (lv != 2'd0) && (int'(lv) < LEVELS);
      win = 2'd0;
      case (it.kind)
         KIND_REQUEST: begin
            same = addressed && lamp_active[lv] && lamp_buzzer[lv] == it.buzzer_mode &&
                   lamp_left[lv] == it.left_color && lamp_right[lv] == it.right_color &&
                   lamp_blink[lv] == it.blink_period;
            if (same) begin
               // identical request: renew the hold only, a zero hold keeps the old one
               if (it.hold_time != 16'd0) begin
                  lamp_hold[lv] = it.hold_time;
                  lamp_start[lv] = now;
               end
            end else if (addressed) begin
               lamp_active[lv] = 1'b1;
               lamp_buzzer[lv] = it.buzzer_mode;
               lamp_left[lv] = it.left_color;
               lamp_right[lv] = it.right_color;
               lamp_blink[lv] = it.blink_period;
               lamp_phase[lv] = 8'd0;
               lamp_phase_ms[lv] = now;
               lamp_hold[lv] = it.hold_time;
               lamp_start[lv] = now;
            end
         end
         KIND_RELEASE: begin
            if (addressed)
               lamp_active[lv] = 1'b0;
         end
         KIND_RELEASE_ALL: begin
            for (int i = 0; i < LEVELS; i++)
               lamp_active[i] = 1'b0;
            latched = PINS_OFF;
         end
         KIND_STEP: begin
            // drop expired timed slots, keep the highest active one
            for (int i = 1; i < LEVELS; i++) begin
               if (lamp_active[i] && lamp_hold[i] != 16'd0 &&
                   now - lamp_start[i] >= 32'(lamp_hold[i]))
                  lamp_active[i] = 1'b0;
               if (lamp_active[i])
                  win = 2'(i);
            end
            if (win == 2'd0) begin
               blink_lit = 1'b1;
               blink_mark = now;
               latched = PINS_OFF;
            end else begin
               // steady winners leave the shared blink phase alone
               if (lamp_blink[win] == 16'd0) begin
                  show = 1'b1;
               end else begin
                  if (now - blink_mark >= 32'(lamp_blink[win])) begin
                     blink_mark = now;
                     blink_lit = ~blink_lit;
                  end
                  show = blink_lit;
               end
               // buzzer: off, always on, or a counted beep train
               if (lamp_buzzer[win] == BUZZER_OFF) begin
                  latched.buzzer = 1'b0;
               end else if (lamp_buzzer[win] == BUZZER_ALWAYS) begin
                  latched.buzzer = 1'b1;
               end else begin
                  beep_end = {lamp_buzzer[win][6:0], 1'b0};
                  if (lamp_phase[win] >= beep_end) begin
                     latched.buzzer = 1'b0;
                  end else begin
                     sounding = ~lamp_phase[win][0];
                     limit_ms = sounding ? beep_on_ms : beep_gap_ms;
                     if (now - lamp_phase_ms[win] >= 32'(limit_ms)) begin
                        lamp_phase[win] = lamp_phase[win] + 8'd1;
                        lamp_phase_ms[win] = now;
                     end
                     latched.buzzer = sounding;
                  end
               end
               // left side has red and green pins swapped
               latched.left = show ? {lamp_left[win][2], lamp_left[win][0], lamp_left[win][1]}
                                   : 3'd0;
               latched.right = show ? lamp_right[win] : 3'd0;
            end
            latched.winner = win;
         end
      endcase
      res = latched;
   endtask

   // Offer one item, wait for it to be taken, record what should come back
   task automatic deliver(input req_item_type it, input bit typed, input pins_type typed_pins);
      pins_type predicted;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= it.kind;
      req_ch.level        <= it.level;
      req_ch.buzzer_mode  <= it.buzzer_mode;
      req_ch.left_color   <= it.left_color;
      req_ch.right_color  <= it.right_color;
      req_ch.blink_period <= it.blink_period;
      req_ch.hold_time    <= it.hold_time;
      req_ch.now_ms       <= it.now_ms;
      do @(posedge clock); while (!req_ch.ready);
      apply_item(it, predicted);
      pin_queue.push_back(typed ? typed_pins : predicted);
      @(negedge clock);
   endtask

   // Drop valid and wait until every result is back and the pipe is empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pin_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_beep_times(input logic [15:0] on_ms, input logic [15:0] gap_ms);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_BEEP_ON;
      csr_ch.data  <= on_ms;
      do @(posedge clock); while (!csr_ch.ready);
      beep_on_ms = on_ms;
      @(negedge clock);
      csr_ch.index <= CSR_BEEP_GAP;
      csr_ch.data  <= gap_ms;
      do @(posedge clock); while (!csr_ch.ready);
      beep_gap_ms = gap_ms;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Build one random item: mostly steps and requests on a running clock,
   // some repeats of a level's last request, releases and raw noise
   task automatic make_item(output req_item_type it);
      int unsigned roll;
      logic [95:0] noise;
      roll = $urandom_range(99);
      it = '0;
      it.level = 2'($urandom_range(1, LEVELS - 1));
      if (roll < 40) begin
         it.kind = KIND_STEP;
         if ($urandom_range(99) < 4)
            clock_ms = $urandom();
         else
            clock_ms += 32'($urandom_range(0, 30));
      end else if (roll < 72) begin
         if (recent_valid[it.level] && $urandom_range(99) < 30) begin
            it = recent_req[it.level];
            it.hold_time = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 200));
         end else begin
            case ($urandom_range(7))
               0:       it.buzzer_mode = BUZZER_OFF;
               1:       it.buzzer_mode = BUZZER_ALWAYS;
               2:       it.buzzer_mode = 8'd128;
               3:       it.buzzer_mode = 8'd129;
               4:       it.buzzer_mode = 8'($urandom_range(255));
               default: it.buzzer_mode = 8'($urandom_range(1, 3));
            endcase
            it.left_color = 3'($urandom_range(7));
            it.right_color = 3'($urandom_range(7));
            roll = $urandom_range(99);
            it.blink_period = (roll < 45) ? 16'd0 :
                              (roll < 95) ? 16'($urandom_range(1, 60)) :
                                            16'($urandom_range(65535));
            roll = $urandom_range(99);
            it.hold_time = (roll < 45) ? 16'd0 :
                           (roll < 95) ? 16'($urandom_range(1, 200)) :
                                         16'($urandom_range(65535));
         end
         it.kind = KIND_REQUEST;
         clock_ms += 32'($urandom_range(0, 5));
         recent_req[it.level] = it;
         recent_valid[it.level] = 1'b1;
      end else if (roll < 82) begin
         it.kind = KIND_RELEASE;
         it.level = 2'($urandom_range(3));
      end else if (roll < 85) begin
         it.kind = KIND_RELEASE_ALL;
      end else begin
         noise = {$urandom(), $urandom(), $urandom()};
         it = req_item_type'(noise[$bits(req_item_type)-1:0]);
         clock_ms = it.now_ms;
      end
      it.now_ms = clock_ms;
   endtask

   // Result sink: stall at random except in the quiet phase
   always @(negedge clock)
      rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

   // Compare each result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      pins_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pin_queue.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pin_queue.pop_front();
            checked++;
            if (rsp_ch.buzzer_drive !== want.buzzer)
               report_mismatch($sformatf("buzzer_drive got %b want %b",
                                         rsp_ch.buzzer_drive, want.buzzer));
            if (rsp_ch.left_pins !== want.left)
               report_mismatch($sformatf("left_pins got %b want %b",
                                         rsp_ch.left_pins, want.left));
            if (rsp_ch.right_pins !== want.right)
               report_mismatch($sformatf("right_pins got %b want %b",
                                         rsp_ch.right_pins, want.right));
            if (rsp_ch.winner_level !== want.winner)
               report_mismatch($sformatf("winner_level got %0d want %0d",
                                         rsp_ch.winner_level, want.winner));
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      req_item_type it;
      int unsigned  counted;
      req_ch.valid        = 1'b0;
      req_ch.kind         = '0;
      req_ch.level        = '0;
      req_ch.buzzer_mode  = '0;
      req_ch.left_color   = '0;
      req_ch.right_color  = '0;
      req_ch.blink_period = '0;
      req_ch.hold_time    = '0;
      req_ch.now_ms       = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;

      // predicted state after reset
      beep_on_ms = BEEP_TIME_RESET;
      beep_gap_ms = BEEP_TIME_RESET;
      for (int i = 0; i < LEVELS; i++) begin
         lamp_active[i] = 1'b0;
         lamp_buzzer[i] = '0;
         lamp_left[i] = '0;
         lamp_right[i] = '0;
         lamp_blink[i] = '0;
         lamp_hold[i] = '0;
         lamp_start[i] = '0;
         lamp_phase[i] = '0;
         lamp_phase_ms[i] = '0;
      end
      blink_mark = '0;
      blink_lit = 1'b1;
      latched = PINS_OFF;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at reset beep timing
      foreach (script[r]) begin
         it = '0;
         it.kind = script[r].kind;
         it.level = script[r].level;
         it.buzzer_mode = script[r].mode;
         it.left_color = script[r].lc;
         it.right_color = script[r].rc;
         it.blink_period = script[r].blink;
         it.hold_time = script[r].hold;
         it.now_ms = script[r].now;
         deliver(it, script[r].typed, script[r].want);
      end

      // random phases, one beep timing setting each
      clock_ms = 32'hFFFF_F000;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         set_beep_times(BEEP_ON_PLAN[p], BEEP_GAP_PLAN[p]);
         quiet = (p == QUIET_PHASE);
         counted = 0;
         while (counted < RANDOM_ITEMS / PHASES) begin
            make_item(it);
            deliver(it, 1'b0, PINS_OFF);
            random_sent++;
            if (!((it.kind == KIND_REQUEST || it.kind == KIND_RELEASE) && it.level == 2'd0))
               counted++;
         end
         quiet = 1'b0;
      end

      settle();
      $display("Ran %0d directed rows and %0d random items over %0d beep timing settings.",
               $size(script), random_sent, PHASES + 1);
      $display("Checked %0d results, %0d mismatches.", checked, errors);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
